// ----- design/bmdf_pkg.sv -----
// Package for the beacon message duplicate filter.
// Holds the beat structs, the header decode result and the protocol constants.
// Depends on nothing.
package bmdf_pkg;

    localparam int DEF_HISTORY_DEPTH = 32;
    localparam int DEF_PAYLOAD_CAP   = 32;

    localparam logic [7:0] MIN_ENTRY_LEN = 8'd5;
    localparam logic [7:0] MAKER_TYPE    = 8'hFF;
    localparam logic [7:0] MAKER_ID_LOW  = 8'h00;
    localparam logic [7:0] MAKER_ID_HIGH = 8'hDE;

    localparam logic OP_RADIO  = 1'b0;
    localparam logic OP_DIRECT = 1'b1;

    localparam logic [1:0] REG_RADIO_GROUP = 2'd0;

    typedef struct packed {
        logic        operation;
        logic [7:0]  entry_length;
        logic [7:0]  entry_type;
        logic [7:0]  maker_low;
        logic [7:0]  maker_high;
        logic [7:0]  group_byte;
        logic [7:0]  sequence_byte;
        logic [47:0] sender_address;
        logic [63:0] direct_id;
    } in_t;

    typedef struct packed {
        logic       header_match;
        logic       fresh;
        logic [5:0] payload_bytes;
    } out_t;

    typedef struct packed {
        logic        ok;
        logic [63:0] id;
        logic [5:0]  bytes;
    } hdr_t;

endpackage

// ----- design/bmdf_hdr.sv -----
// Radio header decoder: validates the first advertising entry and forms the message ID.
// Depends on bmdf_pkg.
module bmdf_hdr
    import bmdf_pkg::*;
#(
    parameter int PAYLOAD_CAP = DEF_PAYLOAD_CAP
)
(
    input  in_t        item,
    input  logic [7:0] radio_group,
    output hdr_t       hdr
);

    localparam logic [7:0] CAP = 8'(PAYLOAD_CAP);

    logic [7:0] diff;

    always_comb
    begin
        diff = item.entry_length - MIN_ENTRY_LEN;
        hdr.ok = (item.entry_length >= MIN_ENTRY_LEN) &&
                 (item.entry_type == MAKER_TYPE) &&
                 (item.maker_low == MAKER_ID_LOW) &&
                 (item.maker_high == MAKER_ID_HIGH) &&
                 (item.group_byte == radio_group);
        hdr.id = {item.sequence_byte, item.group_byte, item.sender_address};
        hdr.bytes = (diff > CAP) ? CAP[5:0] : diff[5:0];
    end

endmodule

// ----- design/bmdf_ring.sv -----
// History ring storage: one write port, one registered read port, per-entry valid bits.
// An entry never written since reset reads as zero. Depends on bmdf_pkg.
module bmdf_ring
    import bmdf_pkg::*;
#(
    parameter int HISTORY_DEPTH = DEF_HISTORY_DEPTH,
    localparam int IDX_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [IDX_W-1:0] rd_addr,
    output logic [63:0]      rd_data,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  logic [63:0]      wr_data
);

    logic [63:0]              mem [HISTORY_DEPTH];
    logic [HISTORY_DEPTH-1:0] valid_reg;
    logic [63:0]              data_reg;
    logic                     hit_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            hit_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            hit_valid_reg <= valid_reg[rd_addr];
        end
    end

    assign rd_data = hit_valid_reg ? data_reg : 64'd0;

endmodule

// ----- design/beacon_message_duplicate_filter.sv -----
// Top level of the beacon message duplicate filter: APB register, sequencer and ID comparator.
// Depends on bmdf_pkg, bmdf_hdr and bmdf_ring.
//
// Channel   Direction  Handshake                  Beat
// item      in         start high, busy low       in_t
// result    out        done strobe, one cycle     out_t
// config    in         APB write, pready high     radio_group at byte address 0
//
// A looked-up item passes through ST_SEARCH and then ST_FINISH before its done strobe, with the
// single history read port and comparator visiting one entry a cycle.
// A radio header that fails the checks gives its result in the next cycle.
// The next item may be accepted in the cycle the previous result is strobed.
// Reset empties the history at once through valid bits; the receiver cannot stall.
module beacon_message_duplicate_filter
    import bmdf_pkg::*;
#(
    parameter int HISTORY_DEPTH = DEF_HISTORY_DEPTH,
    parameter int PAYLOAD_CAP   = DEF_PAYLOAD_CAP
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  in_t         item,
    output logic        done,
    output out_t        result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IDX_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(HISTORY_DEPTH - 1);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SEARCH = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

    state_t           state_reg, state_next;
    logic [7:0]       group_reg;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [IDX_W-1:0] newest_reg, newest_next;
    logic [IDX_W-1:0] slot;
    logic             hit_reg, hit_next;
    logic             cmp_valid_reg;
    logic [63:0]      id_reg, id_next;
    logic             radio_reg, radio_next;
    logic [5:0]       bytes_reg, bytes_next;
    logic             done_reg, done_next;
    out_t             result_reg, result_next;
    logic             hit_now;
    logic             wr_en;
    logic [63:0]      rd_data;
    hdr_t             hdr;

    bmdf_hdr #(
        .PAYLOAD_CAP(PAYLOAD_CAP)
    ) u_hdr (
        .item        (item),
        .radio_group (group_reg),
        .hdr         (hdr)
    );

    bmdf_ring #(
        .HISTORY_DEPTH(HISTORY_DEPTH)
    ) u_ring (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_addr (idx_reg),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (slot),
        .wr_data (id_reg)
    );

    assign pready = 1'b1;
    assign prdata = (paddr == REG_RADIO_GROUP) ? {24'd0, group_reg} : 32'd0;
    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    assign slot    = (newest_reg == '0) ? LAST_IDX : newest_reg - IDX_W'(1);
    assign hit_now = hit_reg | (cmp_valid_reg & (rd_data == id_reg));

    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        newest_next = newest_reg;
        hit_next    = hit_reg;
        id_next     = id_reg;
        radio_next  = radio_reg;
        bytes_next  = bytes_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        wr_en       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    radio_next = (item.operation == OP_RADIO);
                    id_next    = (item.operation == OP_DIRECT) ? item.direct_id : hdr.id;
                    bytes_next = hdr.bytes;
                    idx_next   = '0;
                    hit_next   = 1'b0;
                    if ((item.operation == OP_DIRECT) || hdr.ok)
                    begin
                        state_next = ST_SEARCH;
                    end
                    else
                    begin
                        done_next   = 1'b1;
                        result_next = '0;
                    end
                end
            end
            ST_SEARCH:
            begin
                hit_next = hit_now;
                if (idx_reg == LAST_IDX)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            ST_FINISH:
            begin
                wr_en      = !hit_now;
                state_next = ST_IDLE;
                done_next  = 1'b1;
                if (!hit_now)
                begin
                    newest_next = slot;
                end
                result_next.header_match  = radio_reg;
                result_next.fresh         = !hit_now;
                result_next.payload_bytes = (radio_reg && !hit_now) ? bytes_reg : 6'd0;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            group_reg     <= 8'd0;
            idx_reg       <= '0;
            newest_reg    <= '0;
            hit_reg       <= 1'b0;
            cmp_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            newest_reg    <= newest_next;
            hit_reg       <= hit_next;
            cmp_valid_reg <= (state_reg == ST_SEARCH);
            done_reg      <= done_next;
            if (psel && penable && pwrite && (paddr == REG_RADIO_GROUP))
            begin
                group_reg <= pwdata[7:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg     <= id_next;
        radio_reg  <= radio_next;
        bytes_reg  <= bytes_next;
        result_reg <= result_next;
    end

endmodule

// ----- design/bmdf_checker.sv -----
// Port-level checker for the beacon message duplicate filter, with its bind statement.
// Depends on bmdf_pkg and the top level beacon_message_duplicate_filter.
module bmdf_checker
    import bmdf_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input in_t  item,
    input logic done,
    input out_t result
);

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("Result strobed while the block is still busy.");

    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("Accepted beat neither started a search nor produced a result.");

    a_direct_no_match: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (item.operation == OP_DIRECT)) |=> busy)
        else $error("A direct ID beat skipped the history search.");

    a_bytes_need_match: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.header_match) |-> (result.payload_bytes == 6'd0))
        else $error("Payload count given without a header match.");

    a_bytes_need_fresh: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.fresh) |-> (result.payload_bytes == 6'd0))
        else $error("Payload count given for a duplicate message.");

endmodule

bind beacon_message_duplicate_filter bmdf_checker u_bmdf_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .done   (done),
    .result (result)
);
